// ===== src/a64ex_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// a64ex_pkg: shared types and constants of the A64 subset execute unit
// Operation codes, condition codes, field widths and the result packing.
// ----------------------------------------------------------------------------
package a64ex_pkg;

  // architectural sizes
  localparam int NUM_REGS_DEF = 32;
  localparam int XLEN         = 64;
  localparam int MODE_W       = 5;
  localparam int WORD_W       = 32;
  localparam int IDX_FIELD_W  = 5;

  // result request layout, lowest bit first
  localparam int OUT_PC_LO   = 0;
  localparam int OUT_WR_BIT  = 64;
  localparam int OUT_IDX_LO  = 65;
  localparam int OUT_VAL_LO  = 70;
  localparam int OUT_N_BIT   = 134;
  localparam int OUT_Z_BIT   = 135;
  localparam int OUT_HLT_BIT = 136;
  localparam int OUT_USED_W  = 137;
  localparam int OUT_W       = 144;

  // pre-decoded operation codes
  typedef enum logic [MODE_W-1:0] {
    MODE_HLT   = 5'd0,
    MODE_ADDSI = 5'd1,
    MODE_ADDSR = 5'd2,
    MODE_SUBSI = 5'd3,
    MODE_SUBSR = 5'd4,
    MODE_ANDS  = 5'd5,
    MODE_EOR   = 5'd6,
    MODE_ORR   = 5'd7,
    MODE_B     = 5'd8,
    MODE_BR    = 5'd9,
    MODE_CMP   = 5'd10,
    MODE_BCOND = 5'd11,
    MODE_MOVZ  = 5'd12,
    MODE_SHIFT = 5'd13,
    MODE_MUL   = 5'd14,
    MODE_ADDI  = 5'd15,
    MODE_ADDR  = 5'd16,
    MODE_CBZ   = 5'd17,
    MODE_CBNZ  = 5'd18
  } mode_t;

  // branch condition codes
  localparam logic [3:0] COND_EQ = 4'b0000;
  localparam logic [3:0] COND_NE = 4'b0001;
  localparam logic [3:0] COND_GE = 4'b1010;
  localparam logic [3:0] COND_LT = 4'b1011;
  localparam logic [3:0] COND_GT = 4'b1100;
  localparam logic [3:0] COND_LE = 4'b1101;

  // immediate shift selector and the lsr marker in imms
  localparam logic [1:0] SH_BY_12      = 2'b01;
  localparam logic [5:0] IMMS_ALL_ONES = 6'b111111;

endpackage

// ===== src/a64ex_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// a64ex_ram: generic single write, single read RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module a64ex_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== src/arm64_subset_execute_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// arm64_subset_execute_unit: in-order execute unit for a small A64 subset
// Executes one pre-decoded instruction per request against the register
// file, flags, PC and run bit, and reports the architectural effect.
// ----------------------------------------------------------------------------
// Usage:
//   in_*  : one instruction per request; in_tuser carries the operation code,
//           in_tdata the 32-bit instruction word.
//   out_* : one result request per instruction (next PC, register write,
//           flags, halted), packed into out_tdata.
// Pipeline: an accepted request is registered in operand fetch, executes in
//   the following cycle and its result is registered into out_*.
// Throughput: one instruction per cycle while out_tready is high; a mul holds
//   the execute stage while the low 64 bits of its 64x64 product are built
//   from 32x32 partial products that are registered before the final add.
// Register file: two RAM copies (one per read operand) plus per-entry valid
//   bits; a result written at the same edge as the next fetch is forwarded.
// Reset: registers read as zero, PC and flags are zero, the core runs. No
//   clearing pass is needed. in_tready is low while reset is asserted.
// Stall: when out_tready is low the result holds in the output register; one
//   more instruction waits in the execute stage, then in_tready drops.
// Once halted, later instructions change nothing and report halted.
// ----------------------------------------------------------------------------
module arm64_subset_execute_unit #(
  parameter int NUM_REGS = a64ex_pkg::NUM_REGS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  // instruction channel
  input  logic                          in_tvalid,
  output logic                          in_tready,
  input  logic [a64ex_pkg::MODE_W-1:0]  in_tuser,  // mode [4:0]
  input  logic [a64ex_pkg::WORD_W-1:0]  in_tdata,  // instr_word [31:0]
  // result channel
  output logic                          out_tvalid,
  input  logic                          out_tready,
  // next_pc [63:0], reg_write [64], dest_index [69:65], write_value [133:70],
  // neg_flag [134], zero_flag [135], halted [136], zero fill [143:137]
  output logic [a64ex_pkg::OUT_W-1:0]   out_tdata
);

  localparam int IDX_W = $clog2(NUM_REGS);
  localparam int XL    = a64ex_pkg::XLEN;

  // ---------------------------------------------------------------------------
  // handshake and stage control
  // ---------------------------------------------------------------------------
  logic                 st_valid_r;
  logic [4:0]           st_mode_r;
  logic [31:0]          st_word_r;
  logic                 out_valid_r;
  logic [a64ex_pkg::OUT_W-1:0] out_data_r;
  logic [a64ex_pkg::OUT_W-1:0] out_data_nxt;
  logic                 mul_rdy_r;
  logic                 mul_wait;
  logic                 adv;
  logic                 in_acc;

  // architectural state
  logic [XL-1:0]        pc_r;
  logic                 flag_n_r;
  logic                 flag_z_r;
  logic                 running_r;
  logic [NUM_REGS-1:0]  vld_r;

  // operand capture
  logic                 fwd_a_r;
  logic                 fwd_b_r;
  logic                 vld_a_r;
  logic                 vld_b_r;
  logic [XL-1:0]        fwd_val_r;
  logic [XL-1:0]        ram_a_q;
  logic [XL-1:0]        ram_b_q;
  logic [XL-1:0]        op_a;
  logic [XL-1:0]        op_b;

  // multiply partial products
  logic [XL-1:0]        pp_ll_r;
  logic [31:0]          pp_lh_r;
  logic [31:0]          pp_hl_r;

  // execute results
  logic [XL-1:0]        next_pc;
  logic                 ex_wr;
  logic [XL-1:0]        ex_res;
  logic                 flag_n_nxt;
  logic                 flag_z_nxt;
  logic                 running_nxt;
  logic                 rf_we;
  logic [IDX_W-1:0]     rf_widx;

  // fetch addresses from the incoming request
  logic [IDX_W-1:0]     in_rn;
  logic [IDX_W-1:0]     in_rb;
  logic                 in_is_cb;

  assign mul_wait  = st_valid_r && running_r && (st_mode_r == a64ex_pkg::MODE_MUL)
                     && !mul_rdy_r;
  assign adv       = st_valid_r && !mul_wait && (!out_valid_r || out_tready);
  assign in_tready = rst_n && (!st_valid_r || adv);
  assign in_acc    = in_tvalid && in_tready;

  assign in_is_cb  = (in_tuser == a64ex_pkg::MODE_CBZ) || (in_tuser == a64ex_pkg::MODE_CBNZ);
  assign in_rn     = in_tdata[5 +: IDX_W];
  assign in_rb     = in_is_cb ? in_tdata[0 +: IDX_W] : in_tdata[16 +: IDX_W];

  assign rf_widx   = st_word_r[0 +: IDX_W];
  assign rf_we     = adv && running_r && ex_wr;

  // ---------------------------------------------------------------------------
  // register file: two copies, one per read operand
  // ---------------------------------------------------------------------------
  a64ex_ram #(
    .WIDTH (XL),
    .DEPTH (NUM_REGS)
  ) u_rf_a (
    .clk   (clk),
    .we    (rf_we),
    .waddr (rf_widx),
    .wdata (ex_res),
    .re    (in_acc),
    .raddr (in_rn),
    .rdata (ram_a_q)
  );

  a64ex_ram #(
    .WIDTH (XL),
    .DEPTH (NUM_REGS)
  ) u_rf_b (
    .clk   (clk),
    .we    (rf_we),
    .waddr (rf_widx),
    .wdata (ex_res),
    .re    (in_acc),
    .raddr (in_rb),
    .rdata (ram_b_q)
  );

  // operands: forwarded write, stored value, or zero for never-written entries
  assign op_a = fwd_a_r ? fwd_val_r : (vld_a_r ? ram_a_q : '0);
  assign op_b = fwd_b_r ? fwd_val_r : (vld_b_r ? ram_b_q : '0);

  // ---------------------------------------------------------------------------
  // execute
  // ---------------------------------------------------------------------------
  always_comb begin
    logic [XL-1:0] pc_plus4;
    logic [XL-1:0] imm_v;
    logic [XL-1:0] sh_reg;
    logic [XL-1:0] off26;
    logic [XL-1:0] off19;
    logic [5:0]    sh6;
    logic [3:0]    cond;
    logic [XL-1:0] movz_base;
    logic          take;
    logic          set_nz;

    pc_plus4  = pc_r + XL'(4);
    sh6       = st_word_r[15:10];
    cond      = st_word_r[3:0];
    imm_v     = (st_word_r[23:22] == a64ex_pkg::SH_BY_12)
                ? {40'd0, st_word_r[21:10], 12'd0} : {52'd0, st_word_r[21:10]};
    sh_reg    = op_b << sh6;
    off26     = {{36{st_word_r[25]}}, st_word_r[25:0], 2'b00};
    off19     = {{43{st_word_r[23]}}, st_word_r[23:5], 2'b00};
    movz_base = {48'd0, st_word_r[20:5]};
    take      = 1'b0;
    set_nz    = 1'b0;

    next_pc     = pc_plus4;
    ex_wr       = 1'b0;
    ex_res      = '0;
    flag_n_nxt  = flag_n_r;
    flag_z_nxt  = flag_z_r;
    running_nxt = running_r;

    unique case (st_mode_r)
      a64ex_pkg::MODE_HLT: begin
        running_nxt = 1'b0;
      end
      a64ex_pkg::MODE_ADDSI, a64ex_pkg::MODE_ADDI: begin
        ex_res = op_a + imm_v;
        ex_wr  = 1'b1;
        set_nz = 1'b1;
      end
      a64ex_pkg::MODE_SUBSI: begin
        ex_res = op_a - imm_v;
        ex_wr  = 1'b1;
        set_nz = 1'b1;
      end
      a64ex_pkg::MODE_ADDSR, a64ex_pkg::MODE_ADDR: begin
        ex_res = op_a + sh_reg;
        ex_wr  = 1'b1;
        set_nz = 1'b1;
      end
      a64ex_pkg::MODE_SUBSR: begin
        ex_res = op_a - sh_reg;
        ex_wr  = 1'b1;
        set_nz = 1'b1;
      end
      a64ex_pkg::MODE_CMP: begin
        // flags only, the difference is not written
        ex_res = op_a - sh_reg;
        set_nz = 1'b1;
      end
      a64ex_pkg::MODE_ANDS: begin
        ex_res = op_a & op_b;
        ex_wr  = 1'b1;
        set_nz = 1'b1;
      end
      a64ex_pkg::MODE_EOR: begin
        ex_res = op_a ^ op_b;
        ex_wr  = 1'b1;
      end
      a64ex_pkg::MODE_ORR: begin
        ex_res = op_a | op_b;
        ex_wr  = 1'b1;
      end
      a64ex_pkg::MODE_B: begin
        next_pc = pc_r + off26;
      end
      a64ex_pkg::MODE_BR: begin
        next_pc = op_a;
      end
      a64ex_pkg::MODE_BCOND: begin
        case (cond)
          a64ex_pkg::COND_EQ: take = flag_z_r;
          a64ex_pkg::COND_NE: take = !flag_z_r;
          a64ex_pkg::COND_GT: take = !flag_z_r && !flag_n_r;
          a64ex_pkg::COND_GE: take = !flag_n_r;
          a64ex_pkg::COND_LT: take = flag_n_r;
          a64ex_pkg::COND_LE: take = flag_z_r || flag_n_r;
          default:            running_nxt = 1'b0;
        endcase
        if (take) begin
          next_pc = pc_r + off19;
        end
      end
      a64ex_pkg::MODE_MOVZ: begin
        ex_res = movz_base << {st_word_r[22:21], 4'd0};
        ex_wr  = 1'b1;
      end
      a64ex_pkg::MODE_SHIFT: begin
        // imms of all ones selects lsr by immr, otherwise lsl by 63 - imms
        if (sh6 == a64ex_pkg::IMMS_ALL_ONES) begin
          ex_res = op_a >> st_word_r[21:16];
        end else begin
          ex_res = op_a << (6'd63 - sh6);
        end
        ex_wr      = 1'b1;
        flag_n_nxt = 1'b0;
        flag_z_nxt = (ex_res == '0);
      end
      a64ex_pkg::MODE_MUL: begin
        ex_res = pp_ll_r + {pp_lh_r + pp_hl_r, 32'd0};
        ex_wr  = 1'b1;
      end
      a64ex_pkg::MODE_CBZ: begin
        if (op_b == '0) begin
          next_pc = pc_r + off19;
        end
      end
      a64ex_pkg::MODE_CBNZ: begin
        if (op_b != '0) begin
          next_pc = pc_r + off19;
        end
      end
      default: begin
        // unused codes only step the pc
      end
    endcase

    if (set_nz) begin
      flag_n_nxt = ex_res[XL-1];
      flag_z_nxt = (ex_res == '0);
    end

    // a halted core reports its frozen state
    if (!running_r) begin
      next_pc     = pc_r;
      ex_wr       = 1'b0;
      flag_n_nxt  = flag_n_r;
      flag_z_nxt  = flag_z_r;
      running_nxt = 1'b0;
    end
  end

  // result request packing
  always_comb begin
    out_data_nxt = '0;
    out_data_nxt[a64ex_pkg::OUT_PC_LO +: XL]  = next_pc;
    out_data_nxt[a64ex_pkg::OUT_WR_BIT]       = ex_wr;
    out_data_nxt[a64ex_pkg::OUT_IDX_LO +: a64ex_pkg::IDX_FIELD_W] =
      ex_wr ? a64ex_pkg::IDX_FIELD_W'(rf_widx) : '0;
    out_data_nxt[a64ex_pkg::OUT_VAL_LO +: XL] = ex_wr ? ex_res : '0;
    out_data_nxt[a64ex_pkg::OUT_N_BIT]        = flag_n_nxt;
    out_data_nxt[a64ex_pkg::OUT_Z_BIT]        = flag_z_nxt;
    out_data_nxt[a64ex_pkg::OUT_HLT_BIT]      = !running_nxt;
  end

  // ---------------------------------------------------------------------------
  // control registers, architectural state and output register
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      mul_rdy_r   <= 1'b0;
      pc_r        <= '0;
      flag_n_r    <= 1'b0;
      flag_z_r    <= 1'b0;
      running_r   <= 1'b1;
      vld_r       <= '0;
    end else begin
      // execute stage occupancy
      if (in_acc) begin
        st_valid_r <= 1'b1;
      end else if (adv) begin
        st_valid_r <= 1'b0;
      end

      // multiply partial products ready marker
      if (adv) begin
        mul_rdy_r <= 1'b0;
      end else if (mul_wait) begin
        mul_rdy_r <= 1'b1;
      end

      // result register
      if (adv) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end

      // commit
      if (adv) begin
        pc_r      <= next_pc;
        flag_n_r  <= flag_n_nxt;
        flag_z_r  <= flag_z_nxt;
        running_r <= running_nxt;
      end
      if (rf_we) begin
        vld_r[rf_widx] <= 1'b1;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_acc) begin
      st_mode_r <= in_tuser;
      st_word_r <= in_tdata;
      fwd_a_r   <= rf_we && (rf_widx == in_rn);
      fwd_b_r   <= rf_we && (rf_widx == in_rb);
      vld_a_r   <= vld_r[in_rn];
      vld_b_r   <= vld_r[in_rb];
      fwd_val_r <= ex_res;
    end
    if (mul_wait) begin
      pp_ll_r <= op_a[31:0] * op_b[31:0];
      pp_lh_r <= 32'(op_a[31:0] * op_b[63:32]);
      pp_hl_r <= 32'(op_a[63:32] * op_b[31:0]);
    end
    if (adv) begin
      out_data_r <= out_data_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  // ---------------------------------------------------------------------------
  // assertions
  // ---------------------------------------------------------------------------
`ifndef SYNTHESIS
  // halt is sticky
  a_halt_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    !running_r |=> !running_r)
    else $error("core resumed after halt");

  // a halted core never writes the register file
  a_no_write_halted: assert property (@(posedge clk) disable iff (!rst_n)
    !running_r |-> !rf_we)
    else $error("register write while halted");

  // a multiply never retires before its partial products are registered
  a_mul_order: assert property (@(posedge clk) disable iff (!rst_n)
    mul_wait |-> !adv)
    else $error("multiply retired without partial products");

  // the partial product marker belongs to an occupied stage
  a_mul_rdy_stage: assert property (@(posedge clk) disable iff (!rst_n)
    mul_rdy_r |-> st_valid_r && (st_mode_r == a64ex_pkg::MODE_MUL))
    else $error("stale multiply marker");
`endif

endmodule
